// File: hdl/stu_pkg.sv
`default_nettype none

package stu_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 16;
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [1:0]  error_code;
      logic [31:0] start_offset;
      logic [15:0] token_length;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic [7:0]  bad_char;
      logic        last_of_run;
   } rsp_type;

   // All results that one source byte causes, in delivery order.
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] res;
      logic [1:0]                count;
   } bundle_type;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUM,
      MODE_STR,
      MODE_EQ,
      MODE_BANG,
      MODE_GT,
      MODE_LT,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_ERR
   } mode_type;

   localparam logic [4:0] KIND_EOF    = 5'd0;
   localparam logic [4:0] KIND_IDENT  = 5'd1;
   localparam logic [4:0] KIND_NUMBER = 5'd2;
   localparam logic [4:0] KIND_STRING = 5'd3;
   localparam logic [4:0] KIND_LET    = 5'd4;
   localparam logic [4:0] KIND_ASSIGN = 5'd8;
   localparam logic [4:0] KIND_EQ     = 5'd9;
   localparam logic [4:0] KIND_NE     = 5'd10;
   localparam logic [4:0] KIND_GT     = 5'd11;
   localparam logic [4:0] KIND_GE     = 5'd12;
   localparam logic [4:0] KIND_LT     = 5'd13;
   localparam logic [4:0] KIND_LE     = 5'd14;
   localparam logic [4:0] KIND_SEMI   = 5'd15;
   localparam logic [4:0] KIND_PLUS   = 5'd16;
   localparam logic [4:0] KIND_MINUS  = 5'd17;
   localparam logic [4:0] KIND_STAR   = 5'd18;
   localparam logic [4:0] KIND_SLASH  = 5'd19;
   localparam logic [4:0] KIND_LBRACE = 5'd20;
   localparam logic [4:0] KIND_RBRACE = 5'd21;
   localparam logic [4:0] KIND_LPAREN = 5'd22;
   localparam logic [4:0] KIND_RPAREN = 5'd23;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_BANG       = 2'd2;
   localparam logic [1:0] ERR_UNTERM     = 2'd3;

   // Keyword spellings in kind order: let, show, if, else.
   localparam logic [7:0] KW_TEXT [4][4] = '{
      '{8'h6C, 8'h65, 8'h74, 8'h00},
      '{8'h73, 8'h68, 8'h6F, 8'h77},
      '{8'h69, 8'h66, 8'h00, 8'h00},
      '{8'h65, 8'h6C, 8'h73, 8'h65}
   };
   localparam logic [2:0] KW_LEN [4] = '{3'd3, 3'd4, 3'd2, 3'd4};

endpackage

`default_nettype wire

// File: hdl/source_tokenizer_unit.sv
`default_nettype none

// Streaming tokenizer. Source text arrives one byte per req beat, with
// final_byte set on the last byte of the text. Each rsp beat carries one
// token or error: kind, error code, start offset, length, line, the column
// just after the token, the offending byte, and last_of_run on the final
// result that a given byte caused. A byte causes zero to three results; the
// final byte always ends with an end-of-source result and then the block
// starts over at line 1, column 1, offset 0.
// A byte accepted into the input register is lexed from it combinationally
// once the result queue has room, and its results are registered into the
// queue, whose head result drives rsp. Throughput: one byte per cycle as
// long as each byte causes at most one result and rsp_ready stays high; a
// byte with k results takes k rsp beats. The limit is the single-beat rsp
// port, fed from a two-slot result queue; the per-byte state update itself
// never holds the flow.
// A stalled rsp side fills the queue, then the input register, and then
// req_ready drops; nothing is lost. After a lexical error one error beat is
// sent and later bytes are dropped until the final byte.
// Reset (synchronous, active high) empties the queue and input register and
// returns the scanner to its idle state.

module source_tokenizer_unit
   import stu_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   // Input register: holds one byte until the queue has room for its results.
   logic       in_valid_ff, in_valid_in;
   req_type    in_req_ff;
   logic       space;
   logic       step;
   logic       push;
   bundle_type bundle;

   assign step        = in_valid_ff && space;
   assign req_ready   = !in_valid_ff || space;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
   end

   stu_lexer #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_lexer (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (in_req_ff),
      .bundle (bundle),
      .push   (push)
   );

   stu_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .bundle_in   (bundle),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // The end-of-source result always closes the run of its byte.
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.token_kind == KIND_EOF) &&
       (rsp_payload.error_code == ERR_NONE)) |-> rsp_payload.last_of_run)
      else $error("end-of-source result not marked last of run");

   // Error beats carry no token kind and no text.
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.error_code != ERR_NONE)) |->
      ((rsp_payload.token_kind == KIND_EOF) && (rsp_payload.token_length == 16'd0)))
      else $error("error result with token kind or length");

   // Only an unexpected-character error reports an offending byte.
   a_bad_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.bad_char != 8'h00)) |->
      (rsp_payload.error_code == ERR_UNEXPECTED))
      else $error("offending byte on a result that is not an unexpected character");

   // Line numbers start at one and saturate, so zero never appears.
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.token_line != 16'd0))
      else $error("result with line number zero");
`endif

endmodule

`default_nettype wire

// File: hdl/stu_lexer.sv
`default_nettype none

module stu_lexer
   import stu_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire req_type    req,
   output bundle_type      bundle,
   output logic            push
);

   localparam int CW = COUNTER_WIDTH;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   mode_type         mode_ff, mode_in;
   logic [CW-1:0]    line_ff, line_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [CW-1:0]    sline_ff, sline_in;
   logic [CW-1:0]    scol_ff, scol_in;
   logic [31:0]      off_ff, off_in;
   logic [31:0]      start_ff, start_in;
   logic [3:0]       kw_ff, kw_in;

   mode_type                  m;
   logic [CW-1:0]             ln, cl, lc, sl, sc, colm1;
   logic [31:0]               ts, off_next;
   logic [3:0]                kw;
   logic [1:0]                n;
   rsp_type [MAX_RESULTS-1:0] res;
   logic                      redo, bad;
   logic [4:0]                single;
   logic [7:0]                b;
   logic                      is_alpha, is_digit, is_word;

   function automatic logic [CW-1:0] inc_cnt(input logic [CW-1:0] v);
      return (&v) ? v : CW'(v + 1'b1);
   endfunction

   function automatic logic [15:0] sat16(input logic [CW-1:0] v);
      return (32'(v) > 32'h0000_FFFF) ? 16'hFFFF : 16'(v);
   endfunction

   function automatic logic [3:0] kw_filter(input logic [3:0] k_in, input logic [CW-1:0] idx,
                                            input logic [7:0] ch);
      logic [3:0] k_out;
      k_out = k_in;
      for (int k = 0; k < 4; k++) begin
         if ((idx >= CW'(KW_LEN[k])) || (KW_TEXT[k][idx[1:0]] != ch)) begin
            k_out[k] = 1'b0;
         end
      end
      return k_out;
   endfunction

   function automatic logic [4:0] ident_kind(input logic [3:0] k_in, input logic [CW-1:0] len);
      logic [4:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < 4; k++) begin
         if (k_in[k] && (len == CW'(KW_LEN[k]))) begin
            kind = KIND_LET + 5'(k);
         end
      end
      return kind;
   endfunction

   function automatic rsp_type make_res(input logic [4:0] kind, input logic [1:0] err,
                                        input logic [31:0] start, input logic [15:0] len,
                                        input logic [15:0] line, input logic [15:0] col,
                                        input logic [7:0] bad_byte);
      rsp_type r;
      r.token_kind   = kind;
      r.error_code   = err;
      r.start_offset = start;
      r.token_length = len;
      r.token_line   = line;
      r.token_column = col;
      r.bad_char     = bad_byte;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   assign b        = req.source_byte;
   assign is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   assign is_digit = (b >= 8'h30) && (b <= 8'h39);
   assign is_word  = is_alpha || is_digit || (b == CH_UNDER);
   assign off_next = (&off_ff) ? off_ff : off_ff + 32'd1;

   always_comb begin
      m      = mode_ff;
      ln     = line_ff;
      cl     = col_ff;
      lc     = len_ff;
      sl     = sline_ff;
      sc     = scol_ff;
      ts     = start_ff;
      kw     = kw_ff;
      n      = 2'd0;
      res    = '0;
      redo   = 1'b0;
      bad    = 1'b0;
      single = KIND_EOF;
      colm1  = '0;

      // A pending token either absorbs the byte or is closed by it; a closed
      // identifier, number or operator hands the byte on to the idle rules.
      case (mode_ff)
         MODE_IDLE: begin
            redo = 1'b1;
         end
         MODE_IDENT: begin
            if (is_word) begin
               kw = kw_filter(kw, lc, b);
               lc = inc_cnt(lc);
               cl = inc_cnt(cl);
            end else begin
               res[n] = make_res(ident_kind(kw, lc), ERR_NONE, ts, sat16(lc), sat16(ln),
                                 sat16(cl), 8'h00);
               n = n + 2'd1;
               m = MODE_IDLE;
               redo = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_digit) begin
               lc = inc_cnt(lc);
               cl = inc_cnt(cl);
            end else begin
               res[n] = make_res(KIND_NUMBER, ERR_NONE, ts, sat16(lc), sat16(ln), sat16(cl),
                                 8'h00);
               n = n + 2'd1;
               m = MODE_IDLE;
               redo = 1'b1;
            end
         end
         MODE_STR: begin
            if (b == CH_QUOTE) begin
               cl = inc_cnt(cl);
               res[n] = make_res(KIND_STRING, ERR_NONE, ts, sat16(lc), sat16(ln), sat16(cl),
                                 8'h00);
               n = n + 2'd1;
               m = MODE_IDLE;
            end else begin
               lc = inc_cnt(lc);
               if (b == CH_NL) begin
                  ln = inc_cnt(ln);
                  cl = CW'(1);
               end else begin
                  cl = inc_cnt(cl);
               end
            end
         end
         MODE_EQ, MODE_GT, MODE_LT: begin
            m = MODE_IDLE;
            if (b == CH_EQUAL) begin
               cl = inc_cnt(cl);
               res[n] = make_res((mode_ff == MODE_EQ) ? KIND_EQ :
                                 (mode_ff == MODE_GT) ? KIND_GE : KIND_LE,
                                 ERR_NONE, ts, 16'd2, sat16(ln), sat16(cl), 8'h00);
            end else begin
               res[n] = make_res((mode_ff == MODE_EQ) ? KIND_ASSIGN :
                                 (mode_ff == MODE_GT) ? KIND_GT : KIND_LT,
                                 ERR_NONE, ts, 16'd1, sat16(ln), sat16(cl), 8'h00);
               redo = 1'b1;
            end
            n = n + 2'd1;
         end
         MODE_BANG: begin
            if (b == CH_EQUAL) begin
               cl = inc_cnt(cl);
               res[n] = make_res(KIND_NE, ERR_NONE, ts, 16'd2, sat16(ln), sat16(cl), 8'h00);
               m = MODE_IDLE;
            end else begin
               colm1 = (cl > CW'(1)) ? CW'(cl - 1'b1) : CW'(1);
               res[n] = make_res(KIND_EOF, ERR_BANG, ts, 16'd0, sat16(ln), sat16(colm1),
                                 8'h00);
               m = MODE_ERR;
            end
            n = n + 2'd1;
         end
         MODE_SLASH: begin
            if (b == CH_SLASH) begin
               cl = inc_cnt(cl);
               m = MODE_COMMENT;
            end else begin
               res[n] = make_res(KIND_SLASH, ERR_NONE, ts, 16'd1, sat16(ln), sat16(cl),
                                 8'h00);
               n = n + 2'd1;
               m = MODE_IDLE;
               redo = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (b == CH_NL) begin
               ln = inc_cnt(ln);
               cl = CW'(1);
               m = MODE_IDLE;
            end else begin
               cl = inc_cnt(cl);
            end
         end
         default: begin
         end
      endcase

      // Rules for a byte that arrives between tokens.
      if (redo) begin
         if ((b == CH_SPACE) || (b == CH_TAB)) begin
            cl = inc_cnt(cl);
         end else if (b == CH_NL) begin
            ln = inc_cnt(ln);
            cl = CW'(1);
         end else begin
            ts = off_ff;
            if (is_alpha || is_digit) begin
               m  = is_alpha ? MODE_IDENT : MODE_NUM;
               kw = kw_filter(4'hF, '0, b);
               lc = CW'(1);
               cl = inc_cnt(cl);
            end else if (b == CH_QUOTE) begin
               cl = inc_cnt(cl);
               m  = MODE_STR;
               ts = off_next;
               lc = '0;
               sl = ln;
               sc = cl;
            end else begin
               case (b)
                  CH_EQUAL:  m = MODE_EQ;
                  CH_BANG:   m = MODE_BANG;
                  CH_GT:     m = MODE_GT;
                  CH_LT:     m = MODE_LT;
                  CH_SLASH:  m = MODE_SLASH;
                  CH_SEMI:   single = KIND_SEMI;
                  CH_PLUS:   single = KIND_PLUS;
                  CH_MINUS:  single = KIND_MINUS;
                  CH_STAR:   single = KIND_STAR;
                  CH_LBRACE: single = KIND_LBRACE;
                  CH_RBRACE: single = KIND_RBRACE;
                  CH_LPAREN: single = KIND_LPAREN;
                  CH_RPAREN: single = KIND_RPAREN;
                  default:   bad = 1'b1;
               endcase
               if (bad) begin
                  res[n] = make_res(KIND_EOF, ERR_UNEXPECTED, off_ff, 16'd0, sat16(ln),
                                    sat16(cl), b);
                  n = n + 2'd1;
                  cl = inc_cnt(cl);
                  m = MODE_ERR;
               end else begin
                  cl = inc_cnt(cl);
                  if (single != KIND_EOF) begin
                     res[n] = make_res(single, ERR_NONE, ts, 16'd1, sat16(ln), sat16(cl),
                                       8'h00);
                     n = n + 2'd1;
                  end
               end
            end
         end
      end

      // The final byte closes whatever is pending and ends the source.
      if (req.final_byte) begin
         case (m)
            MODE_IDENT: begin
               res[n] = make_res(ident_kind(kw, lc), ERR_NONE, ts, sat16(lc), sat16(ln),
                                 sat16(cl), 8'h00);
               n = n + 2'd1;
            end
            MODE_NUM: begin
               res[n] = make_res(KIND_NUMBER, ERR_NONE, ts, sat16(lc), sat16(ln), sat16(cl),
                                 8'h00);
               n = n + 2'd1;
            end
            MODE_STR: begin
               res[n] = make_res(KIND_EOF, ERR_UNTERM, ts, 16'd0, sat16(sl), sat16(sc), 8'h00);
               n = n + 2'd1;
            end
            MODE_EQ, MODE_GT, MODE_LT, MODE_SLASH: begin
               res[n] = make_res((m == MODE_EQ) ? KIND_ASSIGN :
                                 (m == MODE_GT) ? KIND_GT :
                                 (m == MODE_LT) ? KIND_LT : KIND_SLASH,
                                 ERR_NONE, ts, 16'd1, sat16(ln), sat16(cl), 8'h00);
               n = n + 2'd1;
            end
            MODE_BANG: begin
               colm1 = (cl > CW'(1)) ? CW'(cl - 1'b1) : CW'(1);
               res[n] = make_res(KIND_EOF, ERR_BANG, ts, 16'd0, sat16(ln), sat16(colm1),
                                 8'h00);
               n = n + 2'd1;
            end
            default: begin
            end
         endcase
         res[n] = make_res(KIND_EOF, ERR_NONE, off_next, 16'd0, sat16(ln), sat16(cl), 8'h00);
         n = n + 2'd1;
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i].last_of_run = (n != 2'd0) && (2'(i) == 2'(n - 2'd1));
      end

      bundle.res   = res;
      bundle.count = n;
      push         = step && (n != 2'd0);

      if (req.final_byte) begin
         mode_in  = MODE_IDLE;
         line_in  = CW'(1);
         col_in   = CW'(1);
         len_in   = '0;
         sline_in = CW'(1);
         scol_in  = CW'(1);
         off_in   = '0;
         start_in = '0;
         kw_in    = 4'hF;
      end else begin
         mode_in  = m;
         line_in  = ln;
         col_in   = cl;
         len_in   = lc;
         sline_in = sl;
         scol_in  = sc;
         off_in   = off_next;
         start_in = ts;
         kw_in    = kw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= CW'(1);
         col_ff   <= CW'(1);
         len_ff   <= '0;
         sline_ff <= CW'(1);
         scol_ff  <= CW'(1);
         off_ff   <= '0;
         start_ff <= '0;
         kw_ff    <= 4'hF;
      end else if (step) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         len_ff   <= len_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         off_ff   <= off_in;
         start_ff <= start_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/stu_out_queue.sv
`default_nettype none

module stu_out_queue
   import stu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire bundle_type  bundle_in,
   output logic             space,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_payload
);

   // Two bundle slots: one being drained, one filling behind it.
   bundle_type slot_ff [2];
   logic       head_ff, head_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] idx_ff, idx_in;
   logic       tail;
   logic       pop_beat, pop_bundle;

   assign space       = (count_ff != 2'd2);
   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot_ff[head_ff].res[idx_ff];
   assign tail        = head_ff ^ count_ff[0];
   assign pop_beat    = rsp_valid && rsp_ready;
   assign pop_bundle  = pop_beat && (idx_ff == 2'(slot_ff[head_ff].count - 2'd1));

   always_comb begin
      head_in  = head_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (pop_bundle) begin
         head_in = ~head_ff;
         idx_in  = 2'd0;
      end else if (pop_beat) begin
         idx_in = idx_ff + 2'd1;
      end
      case ({push, pop_bundle})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         idx_ff   <= 2'd0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail] <= bundle_in;
      end
   end

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import stu_pkg::*;

   // The run is bounded by a cycle count far above the slowest legal run:
   // every byte waiting out the longest request gap and causing three
   // result beats that each sit out the longest response stall.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;
   localparam int TOTAL_BYTES   = 330;
   localparam int DRAIN_CYCLES  = 20;

   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   source_tokenizer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Scanner state mirrored from the block, updated once per accepted byte.
   mode_type    scan_st;
   logic [15:0] cur_line;
   logic [15:0] cur_col;
   logic [15:0] text_len;
   logic [15:0] quote_line;
   logic [15:0] quote_col;
   logic [31:0] cur_offset;
   logic [31:0] text_start;
   logic [3:0]  kw_alive;

   // Tokens produced by the byte being lexed, and every token still owed
   // on the response side, oldest first.
   rsp_type step_tokens[$];
   rsp_type expected_tokens[$];

   // Source text of the next run of bytes; the last one carries final_byte.
   logic [7:0] source_text[$];

   int  fail_count;
   int  sent_bytes;
   bit  burst_mode;
   bit  steady_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

   function automatic logic [31:0] bump_offset(input logic [31:0] v);
      return (v == OFFSET_MAX) ? v : v + 32'd1;
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   task automatic reset_scanner();
      scan_st    = MODE_IDLE;
      cur_line   = 16'd1;
      cur_col    = 16'd1;
      cur_offset = 32'd0;
      text_start = 32'd0;
      text_len   = 16'd0;
      quote_line = 16'd1;
      quote_col  = 16'd1;
      kw_alive   = 4'hF;
   endtask

   task automatic add_token(input logic [4:0] kind, input logic [1:0] err,
                            input logic [31:0] start, input logic [15:0] len,
                            input logic [15:0] ln, input logic [15:0] col,
                            input logic [7:0] bad);
      rsp_type t;
      t.token_kind   = kind;
      t.error_code   = err;
      t.start_offset = start;
      t.token_length = len;
      t.token_line   = ln;
      t.token_column = col;
      t.bad_char     = bad;
      t.last_of_run  = 1'b0;
      if (step_tokens.size() < MAX_RESULTS) step_tokens.push_back(t);
   endtask

   // An ordinary token ends at the current position.
   task automatic add_plain(input logic [4:0] kind, input logic [15:0] len);
      add_token(kind, ERR_NONE, text_start, len, cur_line, cur_col, 8'h00);
   endtask

   // Drop every keyword whose spelling does not continue with this byte.
   task automatic narrow_keywords(input logic [7:0] b);
      for (int k = 0; k < 4; k++) begin
         if (text_len >= KW_LEN[k] || KW_TEXT[k][text_len[1:0]] != b) kw_alive[k] = 1'b0;
      end
   endtask

   task automatic emit_word();
      logic [4:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < 4; k++) begin
         if (kw_alive[k] && text_len == KW_LEN[k]) kind = KIND_LET + 5'(k);
      end
      add_plain(kind, text_len);
   endtask

   // The error column points back at the '!' itself.
   task automatic bang_fault();
      add_token(KIND_EOF, ERR_BANG, text_start, 16'd0, cur_line,
                (cur_col > 16'd1) ? cur_col - 16'd1 : 16'd1, 8'h00);
      scan_st = MODE_ERR;
   endtask

   task automatic scan_idle(input logic [7:0] b, input logic [31:0] pos);
      logic [4:0] single;
      single = KIND_EOF;
      if (b == CH_SPACE || b == CH_TAB) begin
         cur_col = bump(cur_col);
         return;
      end
      if (b == CH_NL) begin
         cur_line = bump(cur_line);
         cur_col  = 16'd1;
         return;
      end
      text_start = pos;
      if (is_letter(b) || is_digit(b)) begin
         scan_st  = is_letter(b) ? MODE_IDENT : MODE_NUM;
         kw_alive = 4'hF;
         text_len = 16'd0;
         narrow_keywords(b);
         text_len = 16'd1;
         cur_col  = bump(cur_col);
         return;
      end
      if (b == CH_QUOTE) begin
         // String text starts after the quote; remember where it opened in
         // case the source ends before the closing quote.
         cur_col    = bump(cur_col);
         scan_st    = MODE_STR;
         text_start = bump_offset(pos);
         text_len   = 16'd0;
         quote_line = cur_line;
         quote_col  = cur_col;
         return;
      end
      case (b)
         "=": scan_st = MODE_EQ;
         "!": scan_st = MODE_BANG;
         ">": scan_st = MODE_GT;
         "<": scan_st = MODE_LT;
         "/": scan_st = MODE_SLASH;
         ";": single = KIND_SEMI;
         "+": single = KIND_PLUS;
         "-": single = KIND_MINUS;
         "*": single = KIND_STAR;
         "{": single = KIND_LBRACE;
         "}": single = KIND_RBRACE;
         "(": single = KIND_LPAREN;
         ")": single = KIND_RPAREN;
         default: begin
            add_token(KIND_EOF, ERR_UNEXPECTED, pos, 16'd0, cur_line, cur_col, b);
            cur_col = bump(cur_col);
            scan_st = MODE_ERR;
            return;
         end
      endcase
      cur_col = bump(cur_col);
      if (single != KIND_EOF) add_plain(single, 16'd1);
   endtask

   // A pending one-character operator either pairs with '=' or is emitted
   // alone, and then the byte is looked at again from the idle state.
   task automatic finish_pair(input logic [7:0] b, input logic [4:0] two,
                              input logic [4:0] one, output bit rescan);
      scan_st = MODE_IDLE;
      rescan  = (b != "=");
      if (!rescan) begin
         cur_col = bump(cur_col);
         add_plain(two, 16'd2);
      end else begin
         add_plain(one, 16'd1);
      end
   endtask

   task automatic flush_pending();
      case (scan_st)
         MODE_IDENT: emit_word();
         MODE_NUM:   add_plain(KIND_NUMBER, text_len);
         MODE_STR:   add_token(KIND_EOF, ERR_UNTERM, text_start, 16'd0,
                               quote_line, quote_col, 8'h00);
         MODE_EQ:    add_plain(KIND_ASSIGN, 16'd1);
         MODE_GT:    add_plain(KIND_GT, 16'd1);
         MODE_LT:    add_plain(KIND_LT, 16'd1);
         MODE_SLASH: add_plain(KIND_SLASH, 16'd1);
         MODE_BANG:  bang_fault();
         default: ;
      endcase
      add_token(KIND_EOF, ERR_NONE, cur_offset, 16'd0, cur_line, cur_col, 8'h00);
   endtask

   // Lex one accepted byte and queue the tokens it causes.
   task automatic lex_byte(input logic [7:0] b, input logic fin);
      bit      again;
      rsp_type t;
      step_tokens.delete();
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (scan_st)
            MODE_IDLE: scan_idle(b, cur_offset);
            MODE_IDENT: begin
               if (is_letter(b) || is_digit(b) || b == "_") begin
                  narrow_keywords(b);
                  text_len = bump(text_len);
                  cur_col  = bump(cur_col);
               end else begin
                  emit_word();
                  scan_st = MODE_IDLE;
                  again   = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(b)) begin
                  text_len = bump(text_len);
                  cur_col  = bump(cur_col);
               end else begin
                  add_plain(KIND_NUMBER, text_len);
                  scan_st = MODE_IDLE;
                  again   = 1'b1;
               end
            end
            MODE_STR: begin
               if (b == CH_QUOTE) begin
                  cur_col = bump(cur_col);
                  add_plain(KIND_STRING, text_len);
                  scan_st = MODE_IDLE;
               end else begin
                  text_len = bump(text_len);
                  if (b == CH_NL) begin
                     cur_line = bump(cur_line);
                     cur_col  = 16'd1;
                  end else begin
                     cur_col = bump(cur_col);
                  end
               end
            end
            MODE_EQ: finish_pair(b, KIND_EQ, KIND_ASSIGN, again);
            MODE_GT: finish_pair(b, KIND_GE, KIND_GT, again);
            MODE_LT: finish_pair(b, KIND_LE, KIND_LT, again);
            MODE_BANG: begin
               if (b == "=") begin
                  cur_col = bump(cur_col);
                  add_plain(KIND_NE, 16'd2);
                  scan_st = MODE_IDLE;
               end else begin
                  bang_fault();
               end
            end
            MODE_SLASH: begin
               // A second slash opens a comment; anything else leaves a divide.
               if (b == "/") begin
                  cur_col = bump(cur_col);
                  scan_st = MODE_COMMENT;
               end else begin
                  add_plain(KIND_SLASH, 16'd1);
                  scan_st = MODE_IDLE;
                  again   = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (b == CH_NL) begin
                  cur_line = bump(cur_line);
                  cur_col  = 16'd1;
                  scan_st  = MODE_IDLE;
               end else begin
                  cur_col = bump(cur_col);
               end
            end
            default: ;
         endcase
      end
      cur_offset = bump_offset(cur_offset);
      if (fin) begin
         flush_pending();
         reset_scanner();
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last_of_run = 1'b1;
         step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endtask

   // ------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------

   function automatic string token_text(input rsp_type t);
      return $sformatf("kind=%0d err=%0d start=%0d len=%0d line=%0d col=%0d bad=%02h last=%0b",
                       t.token_kind, t.error_code, t.start_offset, t.token_length,
                       t.token_line, t.token_column, t.bad_char, t.last_of_run);
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic check_token(input rsp_type got);
      rsp_type want;
      string   wrong;
      if (expected_tokens.size() == 0) begin
         report_failure({"token beat with nothing expected: ", token_text(got)});
         return;
      end
      want  = expected_tokens.pop_front();
      wrong = "";
      if (got.token_kind   !== want.token_kind)   wrong = {wrong, " token_kind"};
      if (got.error_code   !== want.error_code)   wrong = {wrong, " error_code"};
      if (got.start_offset !== want.start_offset) wrong = {wrong, " start_offset"};
      if (got.token_length !== want.token_length) wrong = {wrong, " token_length"};
      if (got.token_line   !== want.token_line)   wrong = {wrong, " token_line"};
      if (got.token_column !== want.token_column) wrong = {wrong, " token_column"};
      if (got.bad_char     !== want.bad_char)     wrong = {wrong, " bad_char"};
      if (got.last_of_run  !== want.last_of_run)  wrong = {wrong, " last_of_run"};
      if (wrong != "") begin
         report_failure($sformatf("token mismatch in%s: expected %s, got %s",
                                  wrong, token_text(want), token_text(got)));
      end
   endtask

   // Handshake signals are read at the clock edge before any driver update
   // of that edge lands, so the values seen are the ones the block saw.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) check_token(rsp_payload);
   end

   // ------------------------------------------------------------------
   // Idling on both sides
   // ------------------------------------------------------------------

   // Draws from three ranges: mostly the shortest, sometimes the middle one, rarely the longest.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(12, 30);
   endfunction

   // Response back-pressure: stalls of random length, broken up now and
   // then by long stretches in which every beat is taken at once.
   initial begin : rsp_backpressure
      int hold;
      int calm;
      int r;
      hold      = 0;
      calm      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (steady_rsp || calm > 0) begin
            if (calm > 0) calm--;
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3) calm = $urandom_range(20, 60);
            else if (r < 30) hold = idle_length();
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Offer one byte, hold it until the block takes it, then predict.
   // Valid stays high between back-to-back beats so it is never lowered
   // and raised within one time step.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = burst_mode ? 0 : ($urandom_range(0, 1) ? idle_length() : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {b, fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_bytes++;
      lex_byte(b, fin);
   endtask

   task automatic send_source();
      foreach (source_text[i]) send_byte(source_text[i], i == source_text.size() - 1);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      source_text.delete();
      add_text(s);
      send_source();
   endtask

   function automatic logic [7:0] random_letter();
      int r;
      r = $urandom_range(0, 51);
      return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   // Printable text for strings and comments, never a quote.
   function automatic logic [7:0] random_printable();
      logic [7:0] c;
      c = 8'($urandom_range(8'h20, 8'h7E));
      return (c == CH_QUOTE) ? 8'("q") : c;
   endfunction

   function automatic string op_spelling(input int i);
      case (i)
         0:  return "=";
         1:  return "==";
         2:  return "!=";
         3:  return ">";
         4:  return ">=";
         5:  return "<";
         6:  return "<=";
         7:  return ";";
         8:  return "+";
         9:  return "-";
         10: return "*";
         11: return "/";
         12: return "{";
         13: return "}";
         14: return "(";
         default: return ")";
      endcase
   endfunction

   function automatic string word_spelling(input int i);
      case (i)
         0: return "let";
         1: return "show";
         2: return "if";
         3: return "else";
         4: return "le";
         5: return "shows";
         6: return "i";
         default: return "elsex";
      endcase
   endfunction

   task automatic add_word();
      int n;
      if ($urandom_range(0, 2) == 0) begin
         add_text(word_spelling($urandom_range(0, 7)));
         return;
      end
      source_text.push_back(random_letter());
      n = $urandom_range(0, 6);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: source_text.push_back(8'($urandom_range("0", "9")));
            1: source_text.push_back("_");
            default: source_text.push_back(random_letter());
         endcase
      end
   endtask

   task automatic add_number();
      int n;
      n = $urandom_range(1, 5);
      repeat (n) source_text.push_back(8'($urandom_range("0", "9")));
   endtask

   task automatic add_string();
      int n;
      n = $urandom_range(0, 8);
      source_text.push_back(CH_QUOTE);
      repeat (n) source_text.push_back(($urandom_range(0, 7) == 0) ? CH_NL : random_printable());
      source_text.push_back(CH_QUOTE);
   endtask

   task automatic add_comment();
      int n;
      n = $urandom_range(0, 8);
      add_text("//");
      repeat (n) source_text.push_back(random_printable());
      source_text.push_back(CH_NL);
   endtask

   task automatic add_blank();
      case ($urandom_range(0, 2))
         0: source_text.push_back(CH_SPACE);
         1: source_text.push_back(CH_TAB);
         default: source_text.push_back(CH_NL);
      endcase
   endtask

   // Mostly well-formed programs with random content, plus some noise and
   // sources that end in the middle of something.
   task automatic build_random_source();
      int n;
      int r;
      source_text.delete();
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 8);
         repeat (n) source_text.push_back(8'($urandom_range(0, 255)));
         return;
      end
      n = $urandom_range(1, 10);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 28) add_word();
         else if (r < 40) add_number();
         else if (r < 50) add_string();
         else if (r < 76) add_text(op_spelling($urandom_range(0, 15)));
         else if (r < 82) add_comment();
         else if (r < 94) add_blank();
         else source_text.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) < 6) add_blank();
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         source_text.push_back(CH_QUOTE);
         source_text.push_back(random_letter());
      end else if (r < 10) begin
         source_text.push_back("!");
      end else if (r < 14) begin
         add_text("//x");
      end
   endtask

   // A comment right after a comment, and a comment still open at the end.
   task automatic test_comment_runs();
      send_text("//\n//z\nq");
      send_text("a//b");
   endtask

   // A newline inside a string, then a string left open at the final byte.
   task automatic test_string_edges();
      send_text("\"a\nb\"");
      send_text("\"x");
   endtask

   // A leading underscore, carriage return, the lowest and highest byte
   // values; later bytes of the same source are dropped after the error.
   task automatic test_unexpected_bytes();
      send_text("_k");
      send_byte(CH_CR, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
   endtask

   // '!' alone at the final byte and '!' followed by something other than '='.
   task automatic test_bang_forms();
      send_text("!");
      send_text("!x");
   endtask

   // A keyword ended by an operator that is itself still pending when the
   // source ends: three beats from one byte.
   task automatic test_pending_at_final();
      send_text("if<");
      send_text("7");
      send_text("=");
   endtask

   // Random sources until the whole run has sent its share of bytes.
   task automatic test_random_sources();
      while (sent_bytes < TOTAL_BYTES) begin
         build_random_source();
         burst_mode = ($urandom_range(0, 4) == 0);
         send_source();
      end
      burst_mode = 1'b0;
   endtask

   // Full rate on both sides for a while.
   task automatic test_back_to_back();
      burst_mode = 1'b1;
      steady_rsp = 1'b1;
      repeat (4) begin
         build_random_source();
         send_source();
      end
      burst_mode = 1'b0;
      steady_rsp = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      fail_count  = 0;
      sent_bytes  = 0;
      burst_mode  = 1'b0;
      steady_rsp  = 1'b0;
      reset_scanner();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_comment_runs();
      test_string_edges();
      test_unexpected_bytes();
      test_bang_forms();
      test_pending_at_final();
      test_back_to_back();
      test_random_sources();

      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
